### design/jrrb_pkg.sv
// jrrb_pkg: shared types, codes and constants of the job receive ring buffer
// holds the transaction structs, op and status codes and the crc-16 byte update
// no dependencies
package jrrb_pkg;

  localparam int BUF_DEPTH = 4096;
  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int FILL_W    = PTR_W + 1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_BEGIN   = 3'd1;
  localparam logic [2:0] OP_HEADER  = 3'd2;
  localparam logic [2:0] OP_DATA    = 3'd3;
  localparam logic [2:0] OP_FINISH  = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;
  localparam logic [2:0] OP_DUP     = 3'd6;
  localparam logic [2:0] OP_ALL_RCV = 3'd7;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_JOB    = 3'd1;
  localparam logic [2:0] ST_INTERNAL   = 3'd2;
  localparam logic [2:0] ST_BAD_OFFSET = 3'd3;
  localparam logic [2:0] ST_NO_SPACE   = 3'd4;
  localparam logic [2:0] ST_BAD_CRC    = 3'd5;
  localparam logic [2:0] ST_EMPTY      = 3'd6;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] job_ident;
    logic [31:0] job_total;
    logic [15:0] crc_expect;
    logic [31:0] chunk_offset;
    logic [15:0] chunk_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_data;
    logic        is_duplicate;
    logic [12:0] fill_level;
    logic [31:0] received_count;
    logic [31:0] consumed_count;
    logic [15:0] crc_now;
    logic        job_ready;
    logic        all_received_flag;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### design/job_receive_ring_buffer_crc_core.sv
// job_receive_ring_buffer_crc_core: top level of the job receive ring buffer
// ties the control block to the ring ram
// depends on jrrb_pkg, jrrb_ctrl, jrrb_ram
//
// usage
// - input channel: drive in_item and raise start; the transaction is taken at a
//   rising edge with start high and busy low
// - every transaction gives exactly one result on out_item, shown for one cycle
//   with out_strobe high; the receiver cannot stall and must take it then
// - the item is registered into item_r with pend_r, then the result into res_r
//   with valid_r, which drives out_strobe; busy stays high for the cycle after
//   accept while the ring ram read data returns and the state is updated
// - a read op pops the byte that the ram fetched at the accepting edge, so the
//   registered ram read is why busy is held after accept
// - reset (rst_n low, synchronous) clears pointers, counters and flags and sets
//   the running crc to 0xFFFF; ring contents are not cleared and are never read
//   before being written, so no clearing pass is needed
module job_receive_ring_buffer_crc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  jrrb_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output jrrb_pkg::out_item_t out_item
);

  jrrb_pkg::ram_req_t ram_req;
  logic [7:0]         ram_rdata;

  jrrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata)
  );

  jrrb_ram #(
    .DEPTH  (jrrb_pkg::BUF_DEPTH),
    .DATA_W (8),
    .ADDR_W (jrrb_pkg::PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

### design/jrrb_ram.sv
// jrrb_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module jrrb_ram #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/jrrb_ctrl.sv
// jrrb_ctrl: job state registers, op decode and result register
// drives the ring ram request and consumes its registered read data
// depends on jrrb_pkg
module jrrb_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  jrrb_pkg::in_item_t             in_item,
  output logic                           out_strobe,
  output jrrb_pkg::out_item_t            out_item,
  output jrrb_pkg::ram_req_t             ram_req,
  input  logic [7:0]                     ram_rdata
);

  localparam int PW = jrrb_pkg::PTR_W;
  localparam int FW = jrrb_pkg::FILL_W;

  logic accept;
  logic pend_r;
  jrrb_pkg::in_item_t item_r;

  logic [PW-1:0] write_ptr_r, write_ptr_nxt;
  logic [PW-1:0] read_ptr_r, read_ptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [31:0]   cur_job_r, cur_job_nxt;
  logic [31:0]   total_r, total_nxt;
  logic [31:0]   recv_r, recv_nxt;
  logic [31:0]   used_r, used_nxt;
  logic [15:0]   crc_target_r, crc_target_nxt;
  logic [15:0]   crc_run_r, crc_run_nxt;
  logic [15:0]   chunk_left_r, chunk_left_nxt;
  logic          receiving_r, receiving_nxt;
  logic          ready_r, ready_nxt;
  logic          all_recv_r, all_recv_nxt;

  logic                valid_r;
  jrrb_pkg::out_item_t res_r, res_nxt;

  logic [2:0]    status;
  logic [7:0]    rdata;
  logic          dup;
  logic [FW-1:0] free_space;
  logic [32:0]   dup_end;
  logic          data_ok;

  assign accept = start && !busy;
  assign busy   = pend_r;

  // ring read is launched at accept, when no other transaction is in flight
  assign data_ok       = pend_r && (item_r.op == jrrb_pkg::OP_DATA) && (chunk_left_r != 16'd0);
  assign ram_req.we    = data_ok;
  assign ram_req.waddr = write_ptr_r;
  assign ram_req.wdata = item_r.data_byte;
  assign ram_req.re    = accept;
  assign ram_req.raddr = read_ptr_r;

  assign free_space = FW'(jrrb_pkg::BUF_DEPTH) - fill_r;
  assign dup_end    = {1'b0, item_r.chunk_offset} + 33'(item_r.chunk_length);

  function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p);
    return (p == PW'(jrrb_pkg::BUF_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    write_ptr_nxt  = write_ptr_r;
    read_ptr_nxt   = read_ptr_r;
    fill_nxt       = fill_r;
    cur_job_nxt    = cur_job_r;
    total_nxt      = total_r;
    recv_nxt       = recv_r;
    used_nxt       = used_r;
    crc_target_nxt = crc_target_r;
    crc_run_nxt    = crc_run_r;
    chunk_left_nxt = chunk_left_r;
    receiving_nxt  = receiving_r;
    ready_nxt      = ready_r;
    all_recv_nxt   = all_recv_r;
    status         = jrrb_pkg::ST_OK;
    rdata          = 8'd0;
    dup            = 1'b0;

    if (pend_r) begin
      unique case (item_r.op)
        jrrb_pkg::OP_CLEAR, jrrb_pkg::OP_BEGIN: begin
          if (item_r.op == jrrb_pkg::OP_BEGIN && item_r.job_total == 32'd0) begin
            status = jrrb_pkg::ST_NO_SPACE;
          end else begin
            write_ptr_nxt  = '0;
            read_ptr_nxt   = '0;
            fill_nxt       = '0;
            cur_job_nxt    = 32'd0;
            total_nxt      = 32'd0;
            recv_nxt       = 32'd0;
            used_nxt       = 32'd0;
            crc_target_nxt = 16'd0;
            crc_run_nxt    = jrrb_pkg::CRC_INIT;
            chunk_left_nxt = 16'd0;
            receiving_nxt  = 1'b0;
            ready_nxt      = 1'b0;
            all_recv_nxt   = 1'b0;
            if (item_r.op == jrrb_pkg::OP_BEGIN) begin
              cur_job_nxt    = item_r.job_ident;
              total_nxt      = item_r.job_total;
              crc_target_nxt = item_r.crc_expect;
              receiving_nxt  = 1'b1;
            end
          end
        end
        jrrb_pkg::OP_HEADER: begin
          priority if (!receiving_r || item_r.job_ident != cur_job_r) begin
            status = jrrb_pkg::ST_BAD_JOB;
          end else if (item_r.chunk_length == 16'd0 || chunk_left_r != 16'd0) begin
            status = jrrb_pkg::ST_INTERNAL;
          end else if (item_r.chunk_offset != recv_r) begin
            status = jrrb_pkg::ST_BAD_OFFSET;
          end else if (item_r.chunk_offset > total_r ||
                       32'(item_r.chunk_length) > (total_r - item_r.chunk_offset)) begin
            status = jrrb_pkg::ST_BAD_OFFSET;
          end else if (32'(item_r.chunk_length) > 32'(free_space)) begin
            status = jrrb_pkg::ST_NO_SPACE;
          end else begin
            chunk_left_nxt = item_r.chunk_length;
          end
        end
        jrrb_pkg::OP_DATA: begin
          if (!data_ok) begin
            status = jrrb_pkg::ST_BAD_OFFSET;
          end else begin
            write_ptr_nxt  = step_ptr(write_ptr_r);
            fill_nxt       = fill_r + 1'b1;
            crc_run_nxt    = jrrb_pkg::crc_byte(crc_run_r, item_r.data_byte);
            recv_nxt       = recv_r + 32'd1;
            chunk_left_nxt = chunk_left_r - 16'd1;
          end
        end
        jrrb_pkg::OP_FINISH: begin
          priority if (!receiving_r || item_r.job_ident != cur_job_r ||
                       item_r.job_total != total_r) begin
            status = jrrb_pkg::ST_BAD_JOB;
          end else if (recv_r != total_r) begin
            status = jrrb_pkg::ST_BAD_OFFSET;
          end else if (item_r.crc_expect != 16'd0 && item_r.crc_expect != crc_target_r) begin
            status = jrrb_pkg::ST_BAD_CRC;
          end else if (crc_target_r != 16'd0 && crc_run_r != crc_target_r) begin
            status = jrrb_pkg::ST_BAD_CRC;
          end else begin
            receiving_nxt = 1'b0;
            ready_nxt     = 1'b1;
          end
        end
        jrrb_pkg::OP_READ: begin
          if (fill_r == '0) begin
            status = jrrb_pkg::ST_EMPTY;
          end else begin
            rdata        = ram_rdata;
            read_ptr_nxt = step_ptr(read_ptr_r);
            fill_nxt     = fill_r - 1'b1;
            used_nxt     = used_r + 32'd1;
          end
        end
        jrrb_pkg::OP_DUP: begin
          dup = (item_r.job_ident == cur_job_r) && (item_r.chunk_length != 16'd0) &&
                (item_r.chunk_offset <= recv_r) && !dup_end[32] &&
                (dup_end[31:0] <= recv_r);
        end
        jrrb_pkg::OP_ALL_RCV: begin
          all_recv_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end

    res_nxt.status            = status;
    res_nxt.read_data         = rdata;
    res_nxt.is_duplicate      = dup;
    res_nxt.fill_level        = 13'(fill_nxt);
    res_nxt.received_count    = recv_nxt;
    res_nxt.consumed_count    = used_nxt;
    res_nxt.crc_now           = crc_run_nxt;
    res_nxt.job_ready         = ready_nxt;
    res_nxt.all_received_flag = all_recv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= 1'b0;
      valid_r      <= 1'b0;
      write_ptr_r  <= '0;
      read_ptr_r   <= '0;
      fill_r       <= '0;
      cur_job_r    <= 32'd0;
      total_r      <= 32'd0;
      recv_r       <= 32'd0;
      used_r       <= 32'd0;
      crc_target_r <= 16'd0;
      crc_run_r    <= jrrb_pkg::CRC_INIT;
      chunk_left_r <= 16'd0;
      receiving_r  <= 1'b0;
      ready_r      <= 1'b0;
      all_recv_r   <= 1'b0;
    end else begin
      pend_r       <= accept;
      valid_r      <= pend_r;
      write_ptr_r  <= write_ptr_nxt;
      read_ptr_r   <= read_ptr_nxt;
      fill_r       <= fill_nxt;
      cur_job_r    <= cur_job_nxt;
      total_r      <= total_nxt;
      recv_r       <= recv_nxt;
      used_r       <= used_nxt;
      crc_target_r <= crc_target_nxt;
      crc_run_r    <= crc_run_nxt;
      chunk_left_r <= chunk_left_nxt;
      receiving_r  <= receiving_nxt;
      ready_r      <= ready_nxt;
      all_recv_r   <= all_recv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (pend_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_strobe = valid_r;
  assign out_item   = res_r;

  a_one_process_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> !pend_r && valid_r)
    else $error("transaction not retired after one process cycle");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> !pend_r)
    else $error("new transaction in flight while result is shown");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(jrrb_pkg::BUF_DEPTH))
    else $error("ring fill exceeds depth");

  a_chunk_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    chunk_left_r != 16'd0 |-> receiving_r)
    else $error("chunk open outside a receiving job");

  a_ram_ports_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.we && ram_req.re))
    else $error("ring write and read launched in the same cycle");

endmodule

### tb/job_receive_ring_buffer_crc_core_tb.sv
// job_receive_ring_buffer_crc_core_tb: self-checking testbench for the job receive ring buffer
// drives chunked jobs, reads and stray commands, predicts every result and checks each strobe
// depends on jrrb_pkg and job_receive_ring_buffer_crc_core
`timescale 1ns / 1ps

module job_receive_ring_buffer_crc_core_tb;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  jrrb_pkg::in_item_t  in_item = '0;
  logic                busy;
  logic                out_strobe;
  jrrb_pkg::out_item_t out_item;

  job_receive_ring_buffer_crc_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  jrrb_pkg::in_item_t  cmd_queue[$];
  jrrb_pkg::out_item_t due_results[$];
  int unsigned sent_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  logic [31:0] last_jid = '0;

  // predicted cache state
  logic [7:0]                 ring_mem [jrrb_pkg::BUF_DEPTH];
  logic [jrrb_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [12:0]                fill_cnt;
  logic [31:0]                job_id, job_size, rx_count, rd_count;
  logic [15:0]                crc_goal, crc_acc, chunk_rem;
  logic                       rx_active, job_done, all_rx_flag;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ 16'h1021;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  task automatic clear_cache();
    wr_ptr = '0;
    rd_ptr = '0;
    fill_cnt = '0;
    job_id = '0;
    job_size = '0;
    rx_count = '0;
    rd_count = '0;
    crc_goal = '0;
    crc_acc = 16'hFFFF;
    chunk_rem = '0;
    rx_active = 1'b0;
    job_done = 1'b0;
    all_rx_flag = 1'b0;
  endtask

  task automatic rx_cache_step(input jrrb_pkg::in_item_t it);
    jrrb_pkg::out_item_t res;
    logic [32:0]         span;
    res = '0;
    res.status = jrrb_pkg::ST_OK;
    case (it.op)
      jrrb_pkg::OP_CLEAR: clear_cache();
      jrrb_pkg::OP_BEGIN: begin
        if (it.job_total == '0) begin
          res.status = jrrb_pkg::ST_NO_SPACE;
        end else begin
          clear_cache();
          job_id = it.job_ident;
          job_size = it.job_total;
          crc_goal = it.crc_expect;
          rx_active = 1'b1;
        end
      end
      jrrb_pkg::OP_HEADER: begin
        if (!rx_active || it.job_ident != job_id) res.status = jrrb_pkg::ST_BAD_JOB;
        else if (it.chunk_length == '0 || chunk_rem != '0) res.status = jrrb_pkg::ST_INTERNAL;
        else if (it.chunk_offset != rx_count) res.status = jrrb_pkg::ST_BAD_OFFSET;
        else if (it.chunk_offset > job_size ||
                 {16'd0, it.chunk_length} > job_size - it.chunk_offset)
          res.status = jrrb_pkg::ST_BAD_OFFSET;
        else if ({16'd0, it.chunk_length} > 32'(jrrb_pkg::BUF_DEPTH) - {19'd0, fill_cnt})
          res.status = jrrb_pkg::ST_NO_SPACE;
        else chunk_rem = it.chunk_length;
      end
      jrrb_pkg::OP_DATA: begin
        if (chunk_rem == '0) begin
          res.status = jrrb_pkg::ST_BAD_OFFSET;
        end else begin
          ring_mem[wr_ptr] = it.data_byte;
          wr_ptr = (wr_ptr == jrrb_pkg::PTR_W'(jrrb_pkg::BUF_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
          fill_cnt = fill_cnt + 1'b1;
          crc_acc = crc16_step(crc_acc, it.data_byte);
          rx_count = rx_count + 1'b1;
          chunk_rem = chunk_rem - 1'b1;
        end
      end
      jrrb_pkg::OP_FINISH: begin
        if (!rx_active || it.job_ident != job_id || it.job_total != job_size)
          res.status = jrrb_pkg::ST_BAD_JOB;
        else if (rx_count != job_size) res.status = jrrb_pkg::ST_BAD_OFFSET;
        else if (it.crc_expect != '0 && it.crc_expect != crc_goal)
          res.status = jrrb_pkg::ST_BAD_CRC;
        else if (crc_goal != '0 && crc_acc != crc_goal) res.status = jrrb_pkg::ST_BAD_CRC;
        else begin
          rx_active = 1'b0;
          job_done = 1'b1;
        end
      end
      jrrb_pkg::OP_READ: begin
        if (fill_cnt == '0) begin
          res.status = jrrb_pkg::ST_EMPTY;
        end else begin
          res.read_data = ring_mem[rd_ptr];
          rd_ptr = (rd_ptr == jrrb_pkg::PTR_W'(jrrb_pkg::BUF_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
          fill_cnt = fill_cnt - 1'b1;
          rd_count = rd_count + 1'b1;
        end
      end
      jrrb_pkg::OP_DUP: begin
        if (it.job_ident == job_id && it.chunk_length != '0 && it.chunk_offset <= rx_count) begin
          span = {1'b0, it.chunk_offset} + {17'd0, it.chunk_length};
          if (!span[32] && span[31:0] <= rx_count) res.is_duplicate = 1'b1;
        end
      end
      jrrb_pkg::OP_ALL_RCV: all_rx_flag = 1'b1;
    endcase
    res.fill_level = fill_cnt;
    res.received_count = rx_count;
    res.consumed_count = rd_count;
    res.crc_now = crc_acc;
    res.job_ready = job_done;
    res.all_received_flag = all_rx_flag;
    due_results.push_back(res);
  endtask

  // driver: bursts of transactions with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_item <= '0;
      clear_cache();
    end else if (!start || !busy) begin
      if (start) rx_cache_step(in_item);
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        in_item <= cmd_queue.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic string show(input jrrb_pkg::out_item_t r);
    return $sformatf("st=%0d rd=%02h dup=%0b fill=%0d rx=%0d used=%0d crc=%04h rdy=%0b all=%0b",
                     r.status, r.read_data, r.is_duplicate, r.fill_level, r.received_count,
                     r.consumed_count, r.crc_now, r.job_ready, r.all_received_flag);
  endfunction

  task automatic log_fail(input string what, input jrrb_pkg::out_item_t want,
                          input jrrb_pkg::out_item_t got);
    err_cnt++;
    if (err_cnt <= 10) $display("%s: expected %s got %s", what, show(want), show(got));
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (due_results.size() == 0) log_fail("unexpected result", '0, out_item);
      else if (out_item !== due_results[0]) log_fail("mismatch", due_results.pop_front(), out_item);
      else void'(due_results.pop_front());
    end
  end

  function automatic jrrb_pkg::in_item_t noise_item();
    jrrb_pkg::in_item_t it;
    it.op = 3'($urandom);
    it.job_ident = $urandom;
    it.job_total = $urandom;
    it.crc_expect = 16'($urandom);
    it.chunk_offset = $urandom;
    it.chunk_length = 16'($urandom);
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  task automatic queue_cmd(input jrrb_pkg::in_item_t it);
    cmd_queue.push_back(it);
    sent_cnt++;
  endtask

  task automatic push_op(input logic [2:0] op);
    jrrb_pkg::in_item_t it;
    it = noise_item();
    it.op = op;
    queue_cmd(it);
  endtask

  task automatic push_job_cmd(input logic [2:0] op, input logic [31:0] jid,
                              input logic [31:0] tot, input logic [15:0] cexp);
    jrrb_pkg::in_item_t it;
    it = noise_item();
    it.op = op;
    it.job_ident = jid;
    it.job_total = tot;
    it.crc_expect = cexp;
    queue_cmd(it);
  endtask

  task automatic push_chunk_cmd(input logic [2:0] op, input logic [31:0] jid,
                                input logic [31:0] off, input logic [15:0] len);
    jrrb_pkg::in_item_t it;
    it = noise_item();
    it.op = op;
    it.job_ident = jid;
    it.chunk_offset = off;
    it.chunk_length = len;
    queue_cmd(it);
  endtask

  task automatic push_data(input logic [7:0] b);
    jrrb_pkg::in_item_t it;
    it = noise_item();
    it.op = jrrb_pkg::OP_DATA;
    it.data_byte = b;
    queue_cmd(it);
  endtask

  task automatic wait_quiet();
    do @(negedge clk); while (cmd_queue.size() != 0 || start || due_results.size() != 0);
  endtask

  // commands that leave an open chunk untouched
  task automatic mid_chunk_noise(input logic [31:0] jid, input int rx_so_far);
    case ($urandom_range(0, 4))
      0: push_op(jrrb_pkg::OP_READ);
      1: push_chunk_cmd(jrrb_pkg::OP_DUP, jid, $urandom_range(0, rx_so_far),
                        16'($urandom_range(0, 20)));
      2: push_chunk_cmd(jrrb_pkg::OP_HEADER, jid, 32'(rx_so_far), 16'($urandom_range(1, 8)));
      3: push_job_cmd(jrrb_pkg::OP_FINISH, jid, $urandom, 16'h0000);
      default: push_op(jrrb_pkg::OP_ALL_RCV);
    endcase
  endtask

  task automatic run_job();
    logic [7:0]  payload[$];
    int          chunk_len[$];
    logic [31:0] jid, body, declared, off;
    logic [15:0] crc, cexp, fin_crc;
    int          nchunks, idx;
    jid = ($urandom_range(0, 2) == 0) ? last_jid : $urandom;
    last_jid = jid;
    nchunks = $urandom_range(1, 4);
    body = 0;
    for (int c = 0; c < nchunks; c++) begin
      chunk_len.push_back(($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                                       : $urandom_range(1, 12));
      body += chunk_len[c];
    end
    crc = 16'hFFFF;
    for (int i = 0; i < body; i++) begin
      payload.push_back(8'($urandom));
      crc = crc16_step(crc, payload[i]);
    end
    declared = body + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 0);
    case ($urandom_range(0, 3))
      0: cexp = 16'h0000;
      1: cexp = 16'($urandom);
      default: cexp = crc;
    endcase
    push_job_cmd(jrrb_pkg::OP_BEGIN, jid, declared, cexp);
    off = 0;
    idx = 0;
    for (int c = 0; c < nchunks; c++) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: push_chunk_cmd(jrrb_pkg::OP_HEADER, jid ^ (32'd1 << $urandom_range(0, 31)), off,
                            16'(chunk_len[c]));
          1: push_chunk_cmd(jrrb_pkg::OP_HEADER, jid, off + $urandom_range(1, 5),
                            16'(chunk_len[c]));
          default: push_chunk_cmd(jrrb_pkg::OP_HEADER, jid, off, 16'd0);
        endcase
      end
      push_chunk_cmd(jrrb_pkg::OP_HEADER, jid, off, 16'(chunk_len[c]));
      for (int k = 0; k < chunk_len[c]; k++) begin
        if ($urandom_range(0, 5) == 0) mid_chunk_noise(jid, idx);
        push_data(payload[idx]);
        idx++;
      end
      off += chunk_len[c];
      if ($urandom_range(0, 11) == 0) push_data(8'($urandom));
      if ($urandom_range(0, 19) == 0) break;
    end
    case ($urandom_range(0, 3))
      0: fin_crc = 16'h0000;
      1: fin_crc = 16'($urandom);
      default: fin_crc = cexp;
    endcase
    push_job_cmd(jrrb_pkg::OP_FINISH, ($urandom_range(0, 15) == 0) ? ~jid : jid,
                 ($urandom_range(0, 15) == 0) ? declared + 1 : declared, fin_crc);
    repeat ($urandom_range(0, body + 2)) push_op(jrrb_pkg::OP_READ);
    if ($urandom_range(0, 3) == 0)
      push_chunk_cmd(jrrb_pkg::OP_DUP, jid, $urandom_range(0, body), 16'($urandom_range(0, 8)));
  endtask

  initial begin
    logic [7:0]  seed_bytes[5];
    logic [15:0] crc;
    logic [31:0] jid;
    int unsigned rand_goal;
    int          pick;
    seed_bytes = '{8'h00, 8'hFF, 8'h5A, 8'h80, 8'h01};
    crc = 16'hFFFF;
    foreach (seed_bytes[i]) crc = crc16_step(crc, seed_bytes[i]);
    jid = 32'hFFFF_FFFF;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // error paths on an idle cache
    push_op(jrrb_pkg::OP_READ);
    push_chunk_cmd(jrrb_pkg::OP_HEADER, 32'd0, 32'd0, 16'd1);
    push_data(8'hFF);
    push_job_cmd(jrrb_pkg::OP_FINISH, 32'd0, 32'd0, 16'd0);
    push_chunk_cmd(jrrb_pkg::OP_DUP, 32'd0, 32'd0, 16'hFFFF);
    push_job_cmd(jrrb_pkg::OP_BEGIN, jid, 32'd0, 16'hFFFF);
    // small job with header checks and finish checks
    push_job_cmd(jrrb_pkg::OP_BEGIN, jid, 32'd5, crc);
    push_chunk_cmd(jrrb_pkg::OP_HEADER, 32'd0, 32'd0, 16'd3);
    push_chunk_cmd(jrrb_pkg::OP_HEADER, jid, 32'd0, 16'd0);
    push_chunk_cmd(jrrb_pkg::OP_HEADER, jid, 32'd1, 16'd2);
    push_chunk_cmd(jrrb_pkg::OP_HEADER, jid, 32'd0, 16'd6);
    push_chunk_cmd(jrrb_pkg::OP_HEADER, jid, 32'd0, 16'd3);
    push_chunk_cmd(jrrb_pkg::OP_HEADER, jid, 32'd0, 16'd3);
    for (int i = 0; i < 3; i++) push_data(seed_bytes[i]);
    push_job_cmd(jrrb_pkg::OP_FINISH, jid, 32'd5, crc);
    push_chunk_cmd(jrrb_pkg::OP_HEADER, jid, 32'd3, 16'd2);
    for (int i = 3; i < 5; i++) push_data(seed_bytes[i]);
    push_chunk_cmd(jrrb_pkg::OP_DUP, jid, 32'd0, 16'd5);
    push_chunk_cmd(jrrb_pkg::OP_DUP, jid, 32'hFFFF_FFFF, 16'hFFFF);
    push_job_cmd(jrrb_pkg::OP_FINISH, jid, 32'd4, crc);
    push_job_cmd(jrrb_pkg::OP_FINISH, jid, 32'd5, crc ^ 16'h0001);
    push_job_cmd(jrrb_pkg::OP_FINISH, jid, 32'd5, 16'h0000);
    push_op(jrrb_pkg::OP_READ);
    push_op(jrrb_pkg::OP_ALL_RCV);
    // chunk longer than the whole ring
    push_job_cmd(jrrb_pkg::OP_BEGIN, 32'd0, 32'hFFFF_FFFF, 16'h0000);
    push_chunk_cmd(jrrb_pkg::OP_HEADER, 32'd0, 32'd0, 16'hFFFF);
    push_op(jrrb_pkg::OP_CLEAR);
    wait_quiet();

    rand_goal = sent_cnt + 1400;
    while (sent_cnt < rand_goal) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) run_job();
      else if (pick < 16) repeat ($urandom_range(1, 10)) push_op(jrrb_pkg::OP_READ);
      else repeat ($urandom_range(1, 4)) queue_cmd(noise_item());
      if ($urandom_range(0, 39) == 0) wait_quiet();
      else while (cmd_queue.size() > 64) @(negedge clk);
    end

    wait_quiet();
    repeat (8) @(negedge clk);
    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
